>>> rtl/core/qtls_pkg.sv
// ----------------------------------------------------------------------------
// qtls_pkg: shared types and character codes for the quoted token splitter
// Holds the scan mode encoding, the result record and the special characters.
// ----------------------------------------------------------------------------
package qtls_pkg;

    typedef enum logic [2:0] {
        MODE_SKIP   = 3'b001,
        MODE_PLAIN  = 3'b010,
        MODE_QUOTED = 3'b100
    } mode_t;

    localparam logic [7:0] CH_NUL       = 8'd0;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_VTAB      = 8'd11;
    localparam logic [7:0] CH_FORMFEED  = 8'd12;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_QUOTE     = 8'd34;
    localparam logic [7:0] CH_HASH      = 8'd35;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;

    localparam int TDATA_W = 24;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       has_byte;
        logic [3:0] arg_index;
        logic       token_start;
        logic       token_end;
        logic       token_drop;
        logic       line_end;
        logic       too_long;
        logic       text_end;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FORMFEED) ||
               (c == CH_RETURN) || (c == CH_SPACE);
    endfunction

endpackage

>>> rtl/core/quoted_token_line_splitter.sv
// ----------------------------------------------------------------------------
// quoted_token_line_splitter: line and token scanner for shell-style text
// Splits a byte stream into lines and argument tokens, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per request in tdata[7:0]; a zero byte ends
//   the text and returns the scanner to its reset state.
//   m_axis carries at most one result per input byte. Bytes that only separate
//   tokens (whitespace, opening quotes, ignored rest of a line) give none.
//   tdata holds the token byte and marks, tuser flags a token byte, tlast
//   marks the end of a line.
// Throughput:
//   One byte per cycle while the skid register is empty. Results are
//   registered. The scan mode machine and the length counters are updated
//   in the accept cycle, so the next byte can follow at once.
// Stall:
//   An output register and a skid register separate the sides; a byte is
//   still taken while one result waits. s_axis_tready drops only when both
//   hold results.
// Reset:
//   aresetn (synchronous, active low) empties both output stages and returns
//   the scanner to whitespace skipping at the start of a line.
// ----------------------------------------------------------------------------
module quoted_token_line_splitter
    import qtls_pkg::*;
#(
    parameter int MAX_ARGS      = 16,
    parameter int MAX_TOKEN_LEN = 255,
    parameter int MAX_LINE_LEN  = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] text_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] token_byte, [11:8] arg_index, [12] token_start, [13] token_end,
    // [14] token_drop, [15] too_long, [16] text_end, [23:17] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // [0] has_byte
    output logic               m_axis_tlast    // line_end
);

    localparam int ARG_CW = $clog2(MAX_ARGS + 1);
    localparam int ARG_W  = (ARG_CW > 4) ? ARG_CW : 4;
    localparam int TOK_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int LINE_W = $clog2(MAX_LINE_LEN + 1);

    localparam logic [ARG_W-1:0]  ARG_LIMIT  = ARG_W'(MAX_ARGS);
    localparam logic [TOK_W-1:0]  TOK_LIMIT  = TOK_W'(MAX_TOKEN_LEN);
    localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(MAX_LINE_LEN);

    mode_t              mode_reg, mode_next;
    logic [ARG_W-1:0]   arg_count_reg, arg_count_next;
    logic [TOK_W-1:0]   token_len_reg, token_len_next;
    logic [LINE_W-1:0]  line_len_reg, line_len_next;
    logic               closed_reg, closed_next;

    result_t            out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;
    result_t            skid_data_reg, skid_data_next;
    logic               skid_valid_reg, skid_valid_next;

    logic [7:0] c;
    logic       accept;
    logic       take;
    logic       is_term;
    logic       has_result;
    logic       r_has, r_start, r_end, r_drop, r_line, r_long, r_text, r_tok;
    result_t    res;

    assign c             = s_axis_tdata;
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && !skid_valid_reg;
    assign take          = out_valid_reg && m_axis_tready;
    assign is_term       = (c == CH_NUL) || (c == CH_NEWLINE) || (c == CH_BACKSLASH);

    // Scanner: next state and result for the byte on s_axis
    always_comb begin
        mode_next      = mode_reg;
        arg_count_next = arg_count_reg;
        token_len_next = token_len_reg;
        line_len_next  = line_len_reg;
        closed_next    = closed_reg;
        r_has   = 1'b0;
        r_start = 1'b0;
        r_end   = 1'b0;
        r_drop  = 1'b0;
        r_line  = 1'b0;
        r_long  = 1'b0;
        r_text  = (c == CH_NUL);
        r_tok   = 1'b0;

        if (!is_term) begin
            if (line_len_reg < LINE_LIMIT) begin
                line_len_next = line_len_reg + 1'b1;
            end
            if (!closed_reg) begin
                case (mode_reg)
                    MODE_SKIP: begin
                        if (is_space(c)) begin
                            // separator between tokens
                        end else if (c == CH_QUOTE) begin
                            mode_next      = MODE_QUOTED;
                            token_len_next = '0;
                        end else if (c == CH_HASH) begin
                            r_drop         = 1'b1;
                            r_tok          = 1'b1;
                            closed_next    = 1'b1;
                            token_len_next = '0;
                        end else begin
                            mode_next = MODE_PLAIN;
                            r_tok     = 1'b1;
                            r_has     = 1'b1;
                            r_start   = 1'b1;
                            token_len_next = TOK_W'(1);
                        end
                    end
                    MODE_PLAIN, MODE_QUOTED: begin
                        if ((mode_reg == MODE_PLAIN && is_space(c)) ||
                            (mode_reg == MODE_QUOTED && c == CH_QUOTE &&
                             token_len_reg != '0)) begin
                            r_end          = 1'b1;
                            r_tok          = 1'b1;
                            arg_count_next = arg_count_reg + 1'b1;
                            closed_next    = (arg_count_reg + 1'b1) >= ARG_LIMIT;
                            mode_next      = MODE_SKIP;
                            token_len_next = '0;
                        end else if (mode_reg == MODE_QUOTED && c == CH_QUOTE) begin
                            // empty quoted token closes the arguments
                            closed_next = 1'b1;
                            mode_next   = MODE_SKIP;
                        end else if (c == CH_HASH) begin
                            r_drop         = 1'b1;
                            r_tok          = 1'b1;
                            closed_next    = 1'b1;
                            mode_next      = MODE_SKIP;
                            token_len_next = '0;
                        end else begin
                            r_tok = 1'b1;
                            if (token_len_reg >= TOK_LIMIT) begin
                                r_long = 1'b1;
                            end else begin
                                r_has          = 1'b1;
                                r_start        = (token_len_reg == '0);
                                token_len_next = token_len_reg + 1'b1;
                            end
                        end
                    end
                    default: begin
                        mode_next = MODE_SKIP;
                    end
                endcase
            end
        end

        // Close the line on a terminator or when it is full; keep an open token
        if (is_term || line_len_next >= LINE_LIMIT) begin
            if (!closed_next && mode_next != MODE_SKIP && token_len_next != '0) begin
                r_end = 1'b1;
                r_tok = 1'b1;
            end
            r_line         = 1'b1;
            mode_next      = MODE_SKIP;
            arg_count_next = '0;
            token_len_next = '0;
            line_len_next  = '0;
            closed_next    = 1'b0;
        end
    end

    assign has_result = r_has || r_end || r_drop || r_line || r_long;

    always_comb begin
        res.token_byte  = r_has ? c : 8'd0;
        res.has_byte    = r_has;
        res.arg_index   = r_tok ? arg_count_reg[3:0] : 4'd0;
        res.token_start = r_start;
        res.token_end   = r_end;
        res.token_drop  = r_drop;
        res.line_end    = r_line;
        res.too_long    = r_long;
        res.text_end    = r_text;
    end

    // Output register with skid stage
    always_comb begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (accept && has_result) begin
            if (!out_valid_reg || take) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SKIP;
            arg_count_reg  <= '0;
            token_len_reg  <= '0;
            line_len_reg   <= '0;
            closed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg      <= mode_next;
                arg_count_reg <= arg_count_next;
                token_len_reg <= token_len_next;
                line_len_reg  <= line_len_next;
                closed_reg    <= closed_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg.text_end, out_data_reg.too_long,
                            out_data_reg.token_drop, out_data_reg.token_end,
                            out_data_reg.token_start, out_data_reg.arg_index,
                            out_data_reg.token_byte};
    assign m_axis_tuser  = out_data_reg.has_byte;
    assign m_axis_tlast  = out_data_reg.line_end;

endmodule

>>> sim/tb_quoted_token_line_splitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_token_line_splitter: self-checking bench for the token splitter
// Drives text bytes with random gaps and checks every token result against
// an in-bench scanner model, with random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb_quoted_token_line_splitter
    import qtls_pkg::*;
();

    localparam int         ARG_LIMIT   = 16;
    localparam logic [7:0] TOKEN_LIMIT = 8'd255;
    localparam logic [7:0] LINE_LIMIT  = 8'd255;
    localparam int         RANDOM_BYTES = 440;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = 8'd0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [7:0] token_byte, [11:8] arg_index, [12] token_start, [13] token_end,
    // [14] token_drop, [15] too_long, [16] text_end, [23:17] zero
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;   // [0] has_byte
    logic               m_axis_tlast;   // line_end

    quoted_token_line_splitter #(
        .MAX_ARGS      (ARG_LIMIT),
        .MAX_TOKEN_LEN (255),
        .MAX_LINE_LEN  (255)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // scanner state mirrored from the block
    mode_t      scan_mode   = MODE_SKIP;
    logic [4:0] arg_count   = '0;
    logic [7:0] token_len   = '0;
    logic [7:0] line_len    = '0;
    logic       args_closed = 1'b0;

    result_t    step_res;
    logic       step_tok;

    result_t    expected_results[$];
    int         fail_count = 0;
    int         byte_count = 0;
    int         src_quiet  = 0;
    int         sink_quiet = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_quoted_token_line_splitter failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_TAB || c == CH_VTAB || c == CH_FORMFEED ||
               c == CH_RETURN || c == CH_SPACE;
    endfunction

    function automatic void restart_line();
        scan_mode   = MODE_SKIP;
        arg_count   = '0;
        token_len   = '0;
        line_len    = '0;
        args_closed = 1'b0;
    endfunction

    function automatic void keep_token();
        step_res.token_end = 1'b1;
        step_tok  = 1'b1;
        arg_count = arg_count + 5'd1;
        if (arg_count >= ARG_LIMIT)
            args_closed = 1'b1;
        scan_mode = MODE_SKIP;
        token_len = '0;
    endfunction

    function automatic void drop_rest_of_line();
        step_res.token_drop = 1'b1;
        step_tok    = 1'b1;
        args_closed = 1'b1;
        scan_mode   = MODE_SKIP;
        token_len   = '0;
    endfunction

    function automatic void append_token_byte(input logic [7:0] c);
        step_tok = 1'b1;
        if (token_len >= TOKEN_LIMIT) begin
            step_res.too_long = 1'b1;
            return;
        end
        step_res.has_byte    = 1'b1;
        step_res.token_byte  = c;
        step_res.token_start = (token_len == 0);
        token_len = token_len + 8'd1;
    endfunction

    function automatic void finish_line();
        if (!args_closed && scan_mode != MODE_SKIP && token_len > 0)
            keep_token();
        step_res.line_end = 1'b1;
        restart_line();
    endfunction

    // advance the model by one accepted text byte, queue its result if any
    function automatic void split_byte(input logic [7:0] c);
        logic [4:0] idx;
        idx      = arg_count;
        step_res = '0;
        step_tok = 1'b0;
        if (c == CH_NUL || c == CH_NEWLINE || c == CH_BACKSLASH) begin
            step_res.text_end = (c == CH_NUL);
            finish_line();
        end else begin
            if (line_len < LINE_LIMIT)
                line_len = line_len + 8'd1;
            if (!args_closed) begin
                case (scan_mode)
                    MODE_SKIP: begin
                        if (is_blank(c)) begin
                        end else if (c == CH_QUOTE) begin
                            scan_mode = MODE_QUOTED;
                            token_len = '0;
                        end else if (c == CH_HASH) begin
                            drop_rest_of_line();
                        end else begin
                            scan_mode = MODE_PLAIN;
                            token_len = '0;
                            append_token_byte(c);
                        end
                    end
                    MODE_PLAIN: begin
                        if (is_blank(c))
                            keep_token();
                        else if (c == CH_HASH)
                            drop_rest_of_line();
                        else
                            append_token_byte(c);
                    end
                    default: begin
                        if (c == CH_QUOTE) begin
                            // an empty quoted token closes the arguments
                            if (token_len > 0) begin
                                keep_token();
                            end else begin
                                args_closed = 1'b1;
                                scan_mode   = MODE_SKIP;
                            end
                        end else if (c == CH_HASH) begin
                            drop_rest_of_line();
                        end else begin
                            append_token_byte(c);
                        end
                    end
                endcase
            end
            if (line_len >= LINE_LIMIT)
                finish_line();
        end
        step_res.arg_index = step_tok ? idx[3:0] : 4'd0;
        if (step_res.has_byte || step_res.token_end || step_res.token_drop ||
            step_res.line_end || step_res.too_long)
            expected_results.push_back(step_res);
    endfunction

    // ------------------------------------------------------------------
    // request driver and result checker
    // ------------------------------------------------------------------
    function automatic int idle_len(inout int quiet);
        int roll;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_len(src_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        split_byte(b);
        byte_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = idle_len(sink_quiet);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: tdata=%h tuser=%b tlast=%b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("token_byte", want.token_byte, m_axis_tdata[7:0]);
                check_field("has_byte", want.has_byte, m_axis_tuser);
                check_field("arg_index", want.arg_index, m_axis_tdata[11:8]);
                check_field("token_start", want.token_start, m_axis_tdata[12]);
                check_field("token_end", want.token_end, m_axis_tdata[13]);
                check_field("token_drop", want.token_drop, m_axis_tdata[14]);
                check_field("line_end", want.line_end, m_axis_tlast);
                check_field("too_long", want.too_long, m_axis_tdata[15]);
                check_field("text_end", want.text_end, m_axis_tdata[16]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_VTAB;
            2:       return CH_FORMFEED;
            3:       return CH_RETURN;
            default: return CH_SPACE;
        endcase
    endfunction

    // any byte that has no special meaning to the scanner
    function automatic logic [7:0] word_char();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CH_NEWLINE || b == CH_BACKSLASH || b == CH_QUOTE ||
               b == CH_HASH || is_blank(b));
        return b;
    endfunction

    task automatic send_random_line();
        int roll;
        int n_tok;
        roll = $urandom_range(0, 99);
        // noise: raw bytes of any value
        if (roll < 8) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        n_tok = $urandom_range(0, 18);
        for (int t = 0; t < n_tok; t++) begin
            repeat ((t == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3))
                send_byte(blank_char());
            roll = $urandom_range(0, 99);
            if (roll < 68) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 29) == 0)
                        send_byte(CH_QUOTE);
                    else if ($urandom_range(0, 59) == 0)
                        send_byte(CH_HASH);
                    else
                        send_byte(word_char());
                end
            end else if (roll < 90) begin
                send_byte(CH_QUOTE);
                repeat ($urandom_range(1, 8))
                    send_byte(($urandom_range(0, 4) == 0) ? blank_char() : word_char());
                // leave the last quote open now and then
                if (t != n_tok - 1 || $urandom_range(0, 3) != 0)
                    send_byte(CH_QUOTE);
            end else if (roll < 95) begin
                send_byte(CH_HASH);
                repeat ($urandom_range(0, 3)) send_byte(word_char());
            end else begin
                send_byte(CH_QUOTE);
                send_byte(CH_QUOTE);
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_byte(blank_char());
        roll = $urandom_range(0, 99);
        if (roll < 60)
            send_byte(CH_NEWLINE);
        else if (roll < 85)
            send_byte(CH_BACKSLASH);
        else
            send_byte(CH_NUL);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_lines();
        send_byte(CH_NEWLINE);
        send_byte(CH_NUL);
        send_byte(CH_BACKSLASH);
    endtask

    task automatic test_quoting();
        send_text("\"\" x\n");
        send_text("a\"b \"p q\"\"r\"\n");
        send_text("\"open");
        send_byte(CH_NUL);
    endtask

    task automatic test_comments();
        send_text("#x\n");
        send_text("ab  #c d\n");
        send_text("cd#e f\\");
    endtask

    task automatic test_byte_range();
        send_byte(8'h01);
        send_byte(CH_TAB);
        send_byte(8'hFF);
        send_byte(CH_VTAB);
        send_byte(8'h80);
        send_byte(CH_FORMFEED);
        send_byte(8'h7F);
        send_byte(CH_RETURN);
        send_byte(CH_SPACE);
        send_byte(8'hAA);
        send_byte(CH_NEWLINE);
    endtask

    task automatic test_arg_limit();
        for (int i = 0; i < ARG_LIMIT + 2; i++) begin
            send_byte(8'("a" + i));
            send_byte(CH_SPACE);
        end
        send_byte(CH_NEWLINE);
    endtask

    task automatic test_forced_line_end();
        // one plain token that fills the whole line
        repeat (LINE_LIMIT) send_byte("k");
        // a quoted token still open when the line fills
        send_byte(CH_QUOTE);
        for (int i = 1; i < LINE_LIMIT; i++)
            send_byte((i % 7 == 0) ? CH_SPACE : "m");
        send_byte(CH_NEWLINE);
    endtask

    task automatic test_random_text();
        int stop_at;
        stop_at = byte_count + RANDOM_BYTES;
        while (byte_count < stop_at)
            send_random_line();
    endtask

    initial begin
        restart_line();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_lines();
        test_quoting();
        test_comments();
        test_byte_range();
        test_arg_limit();
        test_forced_line_end();
        test_random_text();

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        // hold a while to catch any stray result
        repeat (20) @(posedge aclk);

        if (fail_count == 0)
            $display("tb_quoted_token_line_splitter passed");
        else
            $display("tb_quoted_token_line_splitter failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/qtls_pkg.sv
rtl/core/quoted_token_line_splitter.sv
sim/tb_quoted_token_line_splitter.sv
